// ===== sv/ipv4p_pkg.sv =====
// Package for the IPv4 dotted-decimal address parser.
// Holds the character codes, the result type and the address packing function.
// No dependencies.
package ipv4p_pkg;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DOT  = 8'h2e;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [1:0] DOTS_MAX = 2'd3;

    localparam logic [31:0] MASK_24 = 32'h00ff_ffff;
    localparam logic [31:0] MASK_16 = 32'h0000_ffff;
    localparam logic [31:0] MASK_8  = 32'h0000_00ff;
    localparam int          TOP_SHIFT = 24;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
    } res_t;

    // Packs the closed parts and the open part by the number of dots seen.
    function automatic logic [31:0] pack_address(
        input logic [1:0]  dots,
        input logic [7:0]  first,
        input logic [7:0]  second,
        input logic [7:0]  third,
        input logic [31:0] acc
    );
        logic [31:0] top;
        top = {24'd0, first} << TOP_SHIFT;
        unique case (dots)
            2'd0: pack_address = acc;
            2'd1: pack_address = top | (acc & MASK_24);
            2'd2: pack_address = top | {8'd0, second, 16'd0} | (acc & MASK_16);
            default: pack_address = top | {8'd0, second, third, 8'd0} | (acc & MASK_8);
        endcase
    endfunction

endpackage

// ===== sv/ipv4p_in_reg.sv =====
// Input register stage of the IPv4 address parser.
// Captures one character request; depends on no other file.
module ipv4p_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       take,
    output logic       valid,
    output logic [7:0] ch
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;

    // The stage can be refilled whenever it is empty or being drained.
    assign s_ready    = !valid_reg || take;
    assign valid_next = s_valid || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
    end

    assign valid = valid_reg;
    assign ch    = ch_reg;

endmodule

// ===== sv/ipv4p_core.sv =====
// Parsing state and per-character update of the IPv4 address parser.
// Uses ipv4p_pkg for character codes, the result type and packing.
module ipv4p_core
    import ipv4p_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] ch,
    input  logic       fire,
    output logic       is_nul,
    output res_t       result
);

    logic [31:0] acc_reg, acc_next;
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [7:0]  third_reg, third_next;
    logic [1:0]  dots_reg, dots_next;
    logic        rej_reg, rej_next;

    logic        is_digit;
    logic [31:0] acc_times_ten;

    assign is_nul   = (ch == CH_NUL);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

    // acc * 10 + digit, wrapping at 32 bits.
    assign acc_times_ten = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                         + {28'd0, ch[3:0]};

    assign result.ok      = !rej_reg;
    assign result.address = rej_reg ? 32'd0
                          : pack_address(dots_reg, first_reg, second_reg, third_reg, acc_reg);

    always_comb begin
        acc_next    = acc_reg;
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        dots_next   = dots_reg;
        rej_next    = rej_reg;
        priority if (is_nul) begin
            acc_next    = 32'd0;
            first_next  = 8'd0;
            second_next = 8'd0;
            third_next  = 8'd0;
            dots_next   = 2'd0;
            rej_next    = 1'b0;
        end else if (rej_reg) begin
            // Everything up to the terminator is ignored once rejected.
        end else if (is_digit) begin
            acc_next = acc_times_ten;
        end else if (ch == CH_DOT) begin
            if (dots_reg == DOTS_MAX) begin
                rej_next = 1'b1;
            end else begin
                unique case (dots_reg)
                    2'd0: first_next = acc_reg[7:0];
                    2'd1: second_next = acc_reg[7:0];
                    default: third_next = acc_reg[7:0];
                endcase
                dots_next = dots_reg + 2'd1;
                acc_next  = 32'd0;
            end
        end else begin
            rej_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= 32'd0;
            first_reg  <= 8'd0;
            second_reg <= 8'd0;
            third_reg  <= 8'd0;
            dots_reg   <= 2'd0;
            rej_reg    <= 1'b0;
        end else if (fire) begin
            acc_reg    <= acc_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
            dots_reg   <= dots_next;
            rej_reg    <= rej_next;
        end
    end

endmodule

// ===== sv/ipv4p_out_reg.sv =====
// Result register of the IPv4 address parser.
// Uses ipv4p_pkg for the result type.
module ipv4p_out_reg
    import ipv4p_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  res_t        data,
    output logic        free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_address
);

    logic valid_reg;
    res_t data_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            data_reg <= data;
        end
    end

    assign m_valid   = valid_reg;
    assign m_ok      = data_reg.ok;
    assign m_address = data_reg.address;

endmodule

// ===== sv/ipv4_dotted_address_parser.sv =====
// IPv4 dotted-decimal address parser, top level.
// Depends on ipv4p_pkg, ipv4p_in_reg, ipv4p_core and ipv4p_out_reg.
//
// The block takes an address string one character per request on the s_
// channel (s_valid, s_ready, s_ch) and ends it with a NUL byte. Digits build
// up the current part modulo 2^32, dots close parts, and a fourth dot or any
// other character rejects the string. For every NUL byte exactly one result
// request leaves on the m_ channel (m_valid, m_ready, m_ok, m_address); other
// characters produce nothing. A rejected string gives m_ok low and a zero
// address.
//
// A character is registered on acceptance and processed from the input
// register; the result register loads as a NUL byte leaves the input
// register, and m_valid rises with that load. One character is accepted
// every cycle unless a NUL byte waits for a full result register; the
// multiply-by-ten add between input register and parsing state is combinational.
//
// Synchronous active-low reset empties both register stages and clears the
// parsing state. When the receiver stalls, the result stays in the output
// register; characters keep flowing until a further NUL reaches the input
// register, which then holds it and drops s_ready until the result is taken.
module ipv4_dotted_address_parser
    import ipv4p_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [31:0] m_address
);

    logic       in_valid;
    logic [7:0] in_ch;
    logic       take;
    logic       is_nul;
    logic       out_free;
    res_t       result;

    // A character leaves the input register unless it is a terminator that
    // finds the result register still occupied.
    assign take = in_valid && (!is_nul || out_free);

    ipv4p_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_ch    (s_ch),
        .take    (take),
        .valid   (in_valid),
        .ch      (in_ch)
    );

    ipv4p_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ch      (in_ch),
        .fire    (take),
        .is_nul  (is_nul),
        .result  (result)
    );

    ipv4p_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_valid && is_nul),
        .data      (result),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_ok      (m_ok),
        .m_address (m_address)
    );

endmodule

// ===== sv/ipv4p_checker.sv =====
// Port-level checks for the IPv4 address parser, bound to its top level.
// Depends only on the ports of ipv4_dotted_address_parser.
module ipv4p_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_ok,
    input logic [31:0] m_address
);

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_address))
        else $error("result changed while stalled");

    // A rejected string always reports a zero address.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_address == 32'd0)
        else $error("rejected result with non-zero address");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the result register empty the input side never stalls.
    a_no_stall_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

bind ipv4_dotted_address_parser ipv4p_port_checker u_ipv4p_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_ok      (m_ok),
    .m_address (m_address)
);

// ===== test/ipv4p_checker.sv =====
`timescale 1ns / 100ps
// Checker for the IPv4 dotted-decimal address parser: watches both request
// channels, predicts every result from the accepted characters and compares.
// Depends on ipv4p_pkg for the character codes and the result type.
module ipv4p_checker
    import ipv4p_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_ok,
    input  logic [31:0] m_address,
    output int          fail_count,
    output int          pending
);

    localparam int REPORT_MAX = 10;

    logic [31:0] part_acc;
    logic [7:0]  part_a;
    logic [7:0]  part_b;
    logic [7:0]  part_c;
    logic [1:0]  dot_count;
    logic        bad_string;
    res_t        parsed_q[$];

    task automatic clear_parse();
        part_acc   = '0;
        part_a     = '0;
        part_b     = '0;
        part_c     = '0;
        dot_count  = '0;
        bad_string = 1'b0;
    endtask

    task automatic record_fail(input string msg);
        if (fail_count < REPORT_MAX)
            $display("%s", msg);
        fail_count++;
    endtask

    // Advances the parse by one character; a NUL queues the packed address.
    task automatic parse_char(input logic [7:0] c);
        res_t r;
        if (c == CH_NUL) begin
            r.ok = !bad_string;
            if (bad_string) begin
                r.address = '0;
            end else begin
                case (dot_count)
                    2'd0:    r.address = part_acc;
                    2'd1:    r.address = {part_a, part_acc[23:0]};
                    2'd2:    r.address = {part_a, part_b, part_acc[15:0]};
                    default: r.address = {part_a, part_b, part_c, part_acc[7:0]};
                endcase
            end
            parsed_q.push_back(r);
            clear_parse();
        end else if (!bad_string) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                part_acc = part_acc * 32'd10 + {24'd0, c} - {24'd0, CH_ZERO};
            end else if (c == CH_DOT) begin
                case (dot_count)
                    2'd0:    part_a = part_acc[7:0];
                    2'd1:    part_b = part_acc[7:0];
                    2'd2:    part_c = part_acc[7:0];
                    default: bad_string = 1'b1;
                endcase
                if (!bad_string) begin
                    dot_count = dot_count + 2'd1;
                    part_acc  = '0;
                end
            end else begin
                bad_string = 1'b1;
            end
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            clear_parse();
            parsed_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (parsed_q.size() == 0) begin
                    record_fail($sformatf("unexpected result: ok=%0b address=%08h",
                                          m_ok, m_address));
                end else begin
                    want = parsed_q.pop_front();
                    if (m_ok !== want.ok)
                        record_fail($sformatf("ok mismatch: expected %0b, got %0b",
                                              want.ok, m_ok));
                    if (m_address !== want.address)
                        record_fail($sformatf("address mismatch: expected %08h, got %08h",
                                              want.address, m_address));
                end
            end
            if (s_valid && s_ready)
                parse_char(s_ch);
        end
        pending <= parsed_q.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the IPv4 dotted-decimal address parser: clock, reset,
// character stimulus, receiver back-pressure, watchdog and final verdict.
// Depends on ipv4p_pkg, ipv4_dotted_address_parser and ipv4p_checker.
module tb;
    import ipv4p_pkg::*;

    // Roughly 1550 characters in all, of which the directed part takes the
    // first few dozen.
    localparam int CHAR_TARGET  = 1550;
    localparam int IDLE_PCT     = 15;
    // Cycles without any accepted request before the run is declared hung.
    // A correct run never comes near this, even with both sides stalling.
    localparam int STALL_LIMIT  = 2000;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 900;
    localparam int PAUSE_AT     = 1000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch      = 8'd0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_ok;
    logic [31:0] m_address;

    int fail_count;
    int pending;
    int char_count  = 0;
    int stall_count = 0;
    // While quiet is set neither side idles, giving a long back-to-back run.
    bit quiet       = 1'b0;
    bit paused      = 1'b0;

    always #4 aclk = ~aclk;

    ipv4_dotted_address_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_ch      (s_ch),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_ok      (m_ok),
        .m_address (m_address)
    );

    ipv4p_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_ok       (m_ok),
        .m_address  (m_address),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver stalls at random, except during the quiet stretch.
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: any accepted request on either channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Offers one character request, with random idle cycles in front of it,
    // and returns at the edge where it is accepted. Valid is left high so that
    // the next request can follow back to back without a glitch.
    task automatic send_char(input logic [7:0] c);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        char_count++;
        quiet = (char_count >= QUIET_FROM && char_count < QUIET_TO);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i]);
    endtask

    task automatic send_string(input string txt);
        send_text(txt);
        send_char(CH_NUL);
    endtask

    // Lowers valid and holds off until every queued result has been taken.
    // The first edge is waited out so that the count reflects the last request.
    task automatic drain();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending != 0);
    endtask

    // One random string. Most are well-formed addresses of one to four parts
    // with random content, some carry too many dots, and the rest are noise.
    // Any part may pick up a stray byte, which usually rejects the string.
    task automatic send_random_string();
        int roll;
        int parts;
        int len;
        int pick;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            len = $urandom_range(0, 6);
            repeat (len)
                send_char(8'($urandom_range(1, 255)));
        end else begin
            parts = (roll < 25) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            for (int p = 0; p < parts; p++) begin
                if (p != 0)
                    send_char(CH_DOT);
                pick = $urandom_range(0, 99);
                // A small share of parts stay empty, which counts as zero.
                if (pick >= 10 && pick < 85) begin
                    send_text($sformatf("%0d", $urandom_range(0, 255)));
                end else if (pick >= 85) begin
                    // Long digit runs exercise truncation and the wrap of
                    // the accumulator at 2^32.
                    len = $urandom_range(4, 11);
                    repeat (len)
                        send_char(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                if ($urandom_range(0, 99) < 4)
                    send_char(8'($urandom_range(1, 255)));
            end
        end
        send_char(CH_NUL);
    endtask

    initial begin
        repeat (8)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The empty string and empty parts are accepted,
        // four dots reject, a ten-digit number wraps modulo 2^32, a letter
        // rejects and the digit after it is ignored, and a full four-part
        // address is packed byte by byte. Last, the all-ones byte rejects.
        send_string("");
        send_string("1..2");
        send_string("....");
        send_string("4294967296");
        send_string("x9");
        send_string("9.8.7.6");
        send_char(8'hff);
        send_char(CH_NUL);
        drain();

        while (char_count < CHAR_TARGET) begin
            send_random_string();
            if (!paused && char_count >= PAUSE_AT) begin
                drain();
                paused = 1'b1;
            end
        end

        // Let every outstanding result arrive, then allow a few more cycles
        // so that any spurious result would still be caught by the checker.
        drain();
        repeat (8)
            @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ipv4p_pkg.sv
sv/ipv4p_in_reg.sv
sv/ipv4p_core.sv
sv/ipv4p_out_reg.sv
sv/ipv4_dotted_address_parser.sv
sv/ipv4p_checker.sv
test/ipv4p_checker.sv
test/tb.sv
